/* rtl/abkf_pkg.sv */
// Shared types, codes and helpers for the angle / gyro-bias Kalman filter.
// No dependencies; imported by abkf_div, angle_bias_kalman_filter, abkf_checker and tb_top.
package abkf_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] CFG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] CFG_MEASURE_NOISE = 2'd2;

  // Register reset values, unsigned Q8.24
  localparam logic [31:0] ANGLE_NOISE_RESET   = 32'd16777;
  localparam logic [31:0] BIAS_NOISE_RESET    = 32'd50332;
  localparam logic [31:0] MEASURE_NOISE_RESET = 32'd503316;

  localparam int DT_FRAC  = 16;
  localparam int COV_FRAC = 24;

  typedef struct packed {
    logic signed [24:0] new_angle;
    logic signed [27:0] new_rate;
    logic        [15:0] dt;
  } abkf_in_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] bias_estimate;
    logic signed [31:0] unbiased_rate;
  } abkf_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RATE,
    ST_M_ANG,  ST_W_ANG,
    ST_M_P11,  ST_W_P11,
    ST_M_P00,  ST_W_P00,
    ST_M_P11Q, ST_W_P11Q,
    ST_D0_GO,  ST_D0_WAIT,
    ST_D1_GO,  ST_D1_WAIT,
    ST_M_K0Y,  ST_W_K0Y,
    ST_M_K1Y,  ST_W_K1Y,
    ST_M_C00,  ST_W_C00,
    ST_M_C01,  ST_W_C01,
    ST_M_C10,  ST_W_C10,
    ST_M_C11,  ST_W_C11,
    ST_OUT
  } abkf_state_t;

  // Saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -70'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/angle_bias_kalman_filter.sv */
// Top level of the two-state angle / gyro-bias Kalman filter.
// Uses abkf_pkg and abkf_div (shared gain divider).
//
//  channel | signals                          | transfer
//  --------+----------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data      | in_valid && in_ready
//  output  | out_valid, out_ready, out_data   | out_valid && out_ready
//  config  | cfg_we, cfg_addr, cfg_wdata      | cfg_we (index 3 ignored)
//
// One update makes ten passes through the shared 35x33 multiplier (operate,
// then write back) and two divisions.
// in_ready is high only in the idle state; a result waits in the output
// register and the next item is taken meanwhile. Reset (rst, synchronous)
// zeroes the state and restores the noise registers.
module angle_bias_kalman_filter
  import abkf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  abkf_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output abkf_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  abkf_state_t state, state_next;

  logic [31:0] q_angle, q_bias, r_meas;

  logic signed [31:0] angle, bias, cov00, cov01, cov10, cov11;
  logic signed [24:0] meas;
  logic signed [27:0] grate;
  logic        [15:0] dt;
  logic signed [31:0] rate, y, k0, k1, p00o, p01o;
  logic signed [33:0] dtp11;

  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [67:0] prod;
  logic signed [68:0] rnd;
  logic               use24;
  logic signed [34:0] inner;
  logic signed [33:0] s_sum;

  logic               div_start, div_done;
  logic signed [31:0] div_num, div_quot;

  abkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s_sum),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Derived terms
  assign inner = 35'(dtp11) - 35'(cov01) - 35'(cov10) + $signed({3'b000, q_angle});
  assign s_sum = 34'(cov00) + $signed({2'b00, r_meas});
  assign rnd   = use24 ? (69'(prod) + 69'sd8388608) >>> COV_FRAC
                       : (69'(prod) + 69'sd32768) >>> DT_FRAC;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= ANGLE_NOISE_RESET;
      q_bias  <= BIAS_NOISE_RESET;
      r_meas  <= MEASURE_NOISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ANGLE_NOISE:   q_angle <= cfg_wdata;
        CFG_BIAS_NOISE:    q_bias  <= cfg_wdata;
        CFG_MEASURE_NOISE: r_meas  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_RATE;
      ST_RATE:    state_next = ST_M_ANG;
      ST_M_ANG:   state_next = ST_W_ANG;
      ST_W_ANG:   state_next = ST_M_P11;
      ST_M_P11:   state_next = ST_W_P11;
      ST_W_P11:   state_next = ST_M_P00;
      ST_M_P00:   state_next = ST_W_P00;
      ST_W_P00:   state_next = ST_M_P11Q;
      ST_M_P11Q:  state_next = ST_W_P11Q;
      ST_W_P11Q:  state_next = ST_D0_GO;
      ST_D0_GO:   state_next = ST_D0_WAIT;
      ST_D0_WAIT: if (div_done) state_next = ST_D1_GO;
      ST_D1_GO:   state_next = ST_D1_WAIT;
      ST_D1_WAIT: if (div_done) state_next = ST_M_K0Y;
      ST_M_K0Y:   state_next = ST_W_K0Y;
      ST_W_K0Y:   state_next = ST_M_K1Y;
      ST_M_K1Y:   state_next = ST_W_K1Y;
      ST_W_K1Y:   state_next = ST_M_C00;
      ST_M_C00:   state_next = ST_W_C00;
      ST_W_C00:   state_next = ST_M_C01;
      ST_M_C01:   state_next = ST_W_C01;
      ST_W_C01:   state_next = ST_M_C10;
      ST_M_C10:   state_next = ST_W_C10;
      ST_W_C10:   state_next = ST_M_C11;
      ST_M_C11:   state_next = ST_W_C11;
      ST_W_C11:   state_next = ST_OUT;
      ST_OUT:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequencer outputs: handshake, divider start, multiplier operands
  always_comb begin
    in_ready  = (state == ST_IDLE);
    div_start = (state == ST_D0_GO) || (state == ST_D1_GO);
    div_num   = (state == ST_D1_GO) ? cov10 : cov00;
    use24     = 1'b1;
    mul_a     = 35'(k0);
    mul_b     = 33'(y);
    unique case (state)
      ST_M_ANG, ST_W_ANG: begin
        mul_a = 35'(rate);  mul_b = $signed({17'd0, dt}); use24 = 1'b0;
      end
      ST_M_P11, ST_W_P11: begin
        mul_a = 35'(cov11); mul_b = $signed({17'd0, dt}); use24 = 1'b0;
      end
      ST_M_P00, ST_W_P00: begin
        mul_a = inner;      mul_b = $signed({17'd0, dt}); use24 = 1'b0;
      end
      ST_M_P11Q, ST_W_P11Q: begin
        mul_a = $signed({3'b000, q_bias}); mul_b = $signed({17'd0, dt}); use24 = 1'b0;
      end
      ST_M_K1Y, ST_W_K1Y: begin
        mul_a = 35'(k1);    mul_b = 33'(y);
      end
      ST_M_C00, ST_W_C00: begin
        mul_a = 35'(k0);    mul_b = 33'(p00o);
      end
      ST_M_C01, ST_W_C01: begin
        mul_a = 35'(k0);    mul_b = 33'(p01o);
      end
      ST_M_C10, ST_W_C10: begin
        mul_a = 35'(k1);    mul_b = 33'(p00o);
      end
      ST_M_C11, ST_W_C11: begin
        mul_a = 35'(k1);    mul_b = 33'(p01o);
      end
      default: ;
    endcase
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= 68'(mul_a) * 68'(mul_b);
  end

  // Filter state and intermediate terms
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      cov00 <= '0;
      cov01 <= '0;
      cov10 <= '0;
      cov11 <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            meas  <= in_data.new_angle;
            grate <= in_data.new_rate;
            dt    <= in_data.dt;
          end
        end
        ST_RATE:   rate  <= sat32(70'(grate) - 70'(bias));
        ST_W_ANG:  angle <= sat32(70'(angle) + 70'(rnd));
        ST_W_P11:  dtp11 <= rnd[33:0];
        ST_W_P00: begin
          cov00 <= sat32(70'(cov00) + 70'(rnd));
          cov01 <= sat32(70'(cov01) - 70'(dtp11));
          cov10 <= sat32(70'(cov10) - 70'(dtp11));
        end
        ST_W_P11Q: begin
          cov11 <= sat32(70'(cov11) + 70'(rnd));
          p00o  <= cov00;
          p01o  <= cov01;
        end
        ST_D0_GO:   y  <= sat32(70'(meas) - 70'(angle));
        ST_D0_WAIT: if (div_done) k0 <= div_quot;
        ST_D1_WAIT: if (div_done) k1 <= div_quot;
        ST_W_K0Y:  angle <= sat32(70'(angle) + 70'(rnd));
        ST_W_K1Y:  bias  <= sat32(70'(bias) + 70'(rnd));
        ST_W_C00:  cov00 <= sat32(70'(cov00) - 70'(rnd));
        ST_W_C01:  cov01 <= sat32(70'(cov01) - 70'(rnd));
        ST_W_C10:  cov10 <= sat32(70'(cov10) - 70'(rnd));
        ST_W_C11:  cov11 <= sat32(70'(cov11) - 70'(rnd));
        default: ;
      endcase
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      out_data  <= '{filtered_angle: angle, bias_estimate: bias, unbiased_rate: rate};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/abkf_div.sv */
// Signed gain divider: (num * 2^24) / den, truncated toward zero, saturated.
// Restoring radix-2, two quotient bits a cycle. Uses abkf_pkg.
module abkf_div
  import abkf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [33:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int DVD_W = 58;
  localparam int STEPS = DVD_W / 2;

  logic [35:0]      rem;
  logic [DVD_W-1:0] dvd;
  logic [33:0]      dmag;
  logic             neg;
  logic             zero;
  logic             busy;
  logic [4:0]       cnt;

  logic [35:0]      r1, r2;
  logic [DVD_W-1:0] d1, d2;
  logic [32:0]      nmag;

  // Two restoring steps per cycle
  always_comb begin
    r1 = {rem[34:0], dvd[DVD_W-1]};
    d1 = {dvd[DVD_W-2:0], 1'b0};
    if (r1 >= {2'b00, dmag}) begin
      r1 = r1 - {2'b00, dmag};
      d1[0] = 1'b1;
    end
    r2 = {r1[34:0], d1[DVD_W-1]};
    d2 = {d1[DVD_W-2:0], 1'b0};
    if (r2 >= {2'b00, dmag}) begin
      r2 = r2 - {2'b00, dmag};
      d2[0] = 1'b1;
    end
  end

  assign nmag = num[31] ? 33'(-34'(num)) : {1'b0, num};

  // Control: load on start, count down the steps, pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvd  <= {1'b0, nmag, 24'd0};
      dmag <= den[33] ? 34'(-35'(den)) : den;
      neg  <= num[31] ^ den[33];
      zero <= (den == '0);
    end else if (busy) begin
      rem <= r2;
      dvd <= d2;
    end
  end

  // Sign and saturate the magnitude quotient
  always_comb begin
    if (zero) begin
      quot = '0;
    end else if (neg) begin
      if (dvd > 58'd2147483648) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = 32'(-59'(dvd));
      end
    end else if (dvd > 58'd2147483647) begin
      quot = 32'sh7FFF_FFFF;
    end else begin
      quot = dvd[31:0];
    end
  end

endmodule

/* tb/abkf_checker.sv */
// Watches the input and output channels of the angle / gyro-bias Kalman filter,
// predicts each result in fixed point and compares it field by field.
// Depends on abkf_pkg for the payload types and register indexes.
module abkf_checker
  import abkf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  abkf_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  abkf_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // filter state and noise registers, held as the block holds them
  logic [31:0] q_angle, q_bias, r_meas;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  abkf_out_t filter_results[$];

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round to nearest, ties toward +infinity; >>> floors
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  function automatic logic signed [63:0] kalman_gain(input logic signed [63:0] p,
                                                     input logic signed [63:0] s);
    if (s == 0) return 0;
    return clamp32((p * 64'sd16777216) / s);
  endfunction

  task automatic filter_update(input abkf_in_t it);
    logic signed [63:0] meas, grate, dtv, rate, dtp11, inner, s, k0, k1, y, o00, o01;
    abkf_out_t r;
    meas  = 64'(it.new_angle);
    grate = 64'(it.new_rate);
    dtv   = {48'd0, it.dt};
    // predict
    rate  = clamp32(grate - bias);
    ang   = clamp32(ang + rnd(dtv * rate, DT_FRAC));
    dtp11 = rnd(dtv * p11, DT_FRAC);
    inner = dtp11 - p01 - p10 + $signed({32'd0, q_angle});
    p00   = clamp32(p00 + rnd(dtv * inner, DT_FRAC));
    p01   = clamp32(p01 - dtp11);
    p10   = clamp32(p10 - dtp11);
    p11   = clamp32(p11 + rnd({32'd0, q_bias} * dtv, DT_FRAC));
    // gains and correction
    s  = p00 + $signed({32'd0, r_meas});
    k0 = kalman_gain(p00, s);
    k1 = kalman_gain(p10, s);
    y  = clamp32(meas - ang);
    ang  = clamp32(ang + rnd(k0 * y, COV_FRAC));
    bias = clamp32(bias + rnd(k1 * y, COV_FRAC));
    o00 = p00;
    o01 = p01;
    p00 = clamp32(p00 - rnd(k0 * o00, COV_FRAC));
    p01 = clamp32(p01 - rnd(k0 * o01, COV_FRAC));
    p10 = clamp32(p10 - rnd(k1 * o00, COV_FRAC));
    p11 = clamp32(p11 - rnd(k1 * o01, COV_FRAC));
    r.filtered_angle = ang;
    r.bias_estimate  = bias;
    r.unbiased_rate  = rate[31:0];
    filter_results.push_back(r);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    fail_count++;
  endtask

  assign pending = filter_results.size();

  always @(posedge clk) begin
    abkf_out_t want;
    if (rst) begin
      q_angle <= ANGLE_NOISE_RESET;
      q_bias  <= BIAS_NOISE_RESET;
      r_meas  <= MEASURE_NOISE_RESET;
      ang = 0; bias = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
      filter_results.delete();
      fail_count <= 0;
    end else begin
      // apply register writes; unknown indexes drop
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ANGLE_NOISE:   q_angle <= cfg_wdata;
          CFG_BIAS_NOISE:    q_bias  <= cfg_wdata;
          CFG_MEASURE_NOISE: r_meas  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) filter_update(in_data);
      // compare each output transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (filter_results.size() == 0) begin
          report("unexpected result", out_data.filtered_angle, 0);
        end else begin
          want = filter_results.pop_front();
          if (out_data.filtered_angle !== want.filtered_angle)
            report("filtered_angle", out_data.filtered_angle, want.filtered_angle);
          if (out_data.bias_estimate !== want.bias_estimate)
            report("bias_estimate", out_data.bias_estimate, want.bias_estimate);
          if (out_data.unbiased_rate !== want.unbiased_rate)
            report("unbiased_rate", out_data.unbiased_rate, want.unbiased_rate);
        end
      end
    end
  end
endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the angle / gyro-bias Kalman filter.
// Depends on abkf_pkg, angle_bias_kalman_filter and abkf_checker.
module tb_top;
  import abkf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 4000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  abkf_in_t in_data = '0;
  abkf_out_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  bit long_hold = 0;

  always #1 clk = ~clk;

  angle_bias_kalman_filter dut (.*);
  abkf_checker u_checker (.*);

  // count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("angle_bias_kalman_filter: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      w = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // offer one item; valid drops only when a gap follows or the stream ends
  task automatic send(input abkf_in_t it);
    int w;
    w = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // wait for every result, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic abkf_in_t rand_item(input bit gentle);
    abkf_in_t it;
    it.new_angle = 25'($signed($urandom_range(0, 23592960)) - 32'sd11796480);
    it.new_rate  = 28'($signed($urandom_range(0, 262144000)) - 32'sd131072000);
    it.dt        = gentle ? 16'($urandom_range(0, 2000)) : 16'($urandom);
    return it;
  endfunction

  function automatic abkf_in_t mk(input int a, input int r, input int d);
    abkf_in_t it;
    it.new_angle = 25'(a);
    it.new_rate  = 28'(r);
    it.dt        = 16'(d);
    return it;
  endfunction

  initial begin
    logic [31:0] qa, qb, rm;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes with reset noise
    send(mk(0, 0, 0));
    send(mk(11796480, 131072000, 65535));
    send(mk(-11796480, -131072000, 65535));
    send(mk(-11796480, 131072000, 0));
    send(mk(11796480, -131072000, 1));
    send(mk(1, -1, 32768));
    drain();
    // no noise at all, plus a write to the unused index 3
    write_reg(CFG_ANGLE_NOISE, 0);
    write_reg(CFG_BIAS_NOISE, 0);
    write_reg(CFG_MEASURE_NOISE, 0);
    write_reg(2'd3, 32'hFFFF_FFFF);
    send(mk(11796480, 131072000, 65535));
    send(mk(-11796480, 5, 100));
    drain();
    // huge noise: saturating covariance, large gains
    write_reg(CFG_ANGLE_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_BIAS_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_MEASURE_NOISE, 32'h0000_0001);
    repeat (10) send(mk(11796480, -131072000, 65535));
    send(mk(-11796480, 131072000, 65535));
    drain();
    write_reg(CFG_MEASURE_NOISE, 32'hFFFF_FFFF);
    repeat (4) send(mk(-11796480, 131072000, 65535));
    drain();

    // random phases with varied noise settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin qa = ANGLE_NOISE_RESET; qb = BIAS_NOISE_RESET; rm = MEASURE_NOISE_RESET; end
        1: begin qa = $urandom; qb = $urandom; rm = $urandom; end
        2: begin qa = $urandom_range(0, 1 << 20); qb = $urandom_range(0, 1 << 20);
                 rm = $urandom_range(0, 1 << 24); end
        default: begin qa = 32'hFFFF_FFFF; qb = 0; rm = $urandom_range(0, 3); end
      endcase
      write_reg(CFG_ANGLE_NOISE, qa);
      write_reg(CFG_BIAS_NOISE, qb);
      write_reg(CFG_MEASURE_NOISE, rm);
      if (ph == 2) long_hold = 1;
      for (int i = 0; i < 115; i++) send(rand_item($urandom_range(0, 3) != 0));
      drain();
    end

    if (fail_count == 0) begin
      $display("angle_bias_kalman_filter: match");
    end else begin
      $display("angle_bias_kalman_filter: mismatch");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/abkf_pkg.sv
rtl/abkf_div.sv
rtl/angle_bias_kalman_filter.sv
tb/abkf_checker.sv
tb/tb_top.sv
